[src/assert_macros.svh]
// Assertion macros shared by the heart rate core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/pphr_pkg.sv]
// Types, constants and codes for the pulse period heart rate core.
package pphr_pkg;

   // field widths
   localparam int PERIOD_W   = 16;
   localparam int RATE_W     = 8;
   localparam int RC_W       = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // shared divider widths
   localparam int DIV_DIVIDEND_W = 32;
   localparam int DIV_DIVISOR_W  = 16;
   localparam int DIV_STEP_W     = 6;

   // default averaging window
   localparam int WINDOW_COUNT_DEF = 3;

   // register reset values
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST    = 16'd4600;
   localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST    = 16'd12000;
   localparam logic [RC_W-1:0]     RATE_CONSTANT_RST = 32'd600000;

   localparam logic [RATE_W-1:0] RATE_MAX = 8'hFF;

   // request action codes
   localparam logic ACTION_CAPTURE = 1'b0;
   localparam logic ACTION_READ    = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PERIOD    = 2'd0,
      CSR_MAX_PERIOD    = 2'd1,
      CSR_RATE_CONSTANT = 2'd2
   } csr_index_type;

   // divider command
   typedef struct packed {
      logic                      start;
      logic [DIV_STEP_W-1:0]     steps;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
   } div_req_type;

   // divider status
   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
   } div_sts_type;

endpackage

[src/pphr_if.sv]
// Handshake channel interfaces for the heart rate core.

// Request channel: capture or read.
interface pphr_req_if import pphr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [PERIOD_W-1:0] period;

   modport source (output valid, output action, output period, input ready);
   modport sink   (input valid, input action, input period, output ready);
endinterface

// Response channel: rate result.
interface pphr_rsp_if import pphr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate;
   logic              done_res;

   modport source (output valid, output rate, output done_res, input ready);
   modport sink   (input valid, input rate, input done_res, output ready);
endinterface

// Configuration write channel.
interface pphr_csr_if import pphr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/pphr_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module pphr_div import pphr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_sts_type div_sts
);

   logic [DIV_DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIV_DIVISOR_W-1:0]  dvsr_ff, dvsr_in;
   logic [DIV_STEP_W-1:0]     cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [DIV_DIVISOR_W:0] shifted;
   logic [DIV_DIVISOR_W:0] diff;
   logic                   ge;

   // trial subtract of the divisor from the shifted remainder
   assign shifted = {rem_ff, quo_ff[DIV_DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvsr_ff};
   assign ge      = (shifted >= {1'b0, dvsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvsr_in = div_req.divisor;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DIVISOR_W-1:0] : shifted[DIV_DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - DIV_STEP_W'(1);
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control under reset, datapath free running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

[src/pulse_period_heart_rate_core.sv]
// Top level of the pulse period heart rate core.
//
//   channel    direction  payload                      use
//   req_chan   in         action, period               beat capture or rate read
//   rsp_chan   out        rate, done_res               one result per read
//   csr_chan   in         index, data                  min/max period, rate constant
//
// A capture is taken in ST_IDLE; a read with nothing pending passes through ST_EMIT
// into the output register. A read of a pending measurement goes through ST_SUM,
// ST_AVG and ST_RATE on the shared divider, which delivers one quotient bit per
// cycle: first sum / WINDOW_COUNT, then rate_constant / average (skipped for a zero
// average, which gives RATE_MAX). req_chan.ready is low while a read is worked on.
// A finished result waits in the output register; reset is synchronous.
`include "assert_macros.svh"

module pulse_period_heart_rate_core import pphr_pkg::*; #(
   parameter int WINDOW_COUNT = WINDOW_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pphr_req_if.sink     req_chan,
   pphr_rsp_if.source   rsp_chan,
   pphr_csr_if.sink     csr_chan
);

   localparam int IDX_W = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
   localparam int SUM_W = PERIOD_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_AVG,
      ST_RATE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [PERIOD_W-1:0] min_ff, min_in;
   logic [PERIOD_W-1:0] max_ff, max_in;
   logic [RC_W-1:0]     rc_ff, rc_in;

   // beat tracking
   logic [IDX_W-1:0]    vc_ff, vc_in;
   logic                ready_ff, ready_in;
   logic [PERIOD_W-1:0] intervals_ff [WINDOW_COUNT];
   logic                wr_en;

   // read sequencing
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDX_W-1:0]  sidx_ff, sidx_in;
   logic [RATE_W-1:0] res_rate_ff, res_rate_in;
   logic              res_done_ff, res_done_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rsp_rate_ff, rsp_rate_in;
   logic              rsp_done_ff, rsp_done_in;

   div_req_type div_req;
   div_sts_type div_sts;

   logic req_xfer;
   logic csr_xfer;
   logic in_window;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign csr_xfer  = csr_chan.valid;
   assign in_window = (req_chan.period > min_ff) && (req_chan.period < max_ff);

   pphr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // configuration writes
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      rc_in  = rc_ff;
      if (csr_xfer) begin
         case (csr_chan.index)
            CSR_MIN_PERIOD:    min_in = csr_chan.data[PERIOD_W-1:0];
            CSR_MAX_PERIOD:    max_in = csr_chan.data[PERIOD_W-1:0];
            CSR_RATE_CONSTANT: rc_in  = csr_chan.data[RC_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vc_in        = vc_ff;
      ready_in     = ready_ff;
      wr_en        = 1'b0;
      sum_in       = sum_ff;
      sidx_in      = sidx_ff;
      res_rate_in  = res_rate_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_done_in  = rsp_done_ff;
      div_req      = '0;

      // output transfer frees the register
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.action == ACTION_CAPTURE) begin
                  if (!ready_ff) begin
                     if (in_window) begin
                        wr_en = 1'b1;
                        if (vc_ff == LAST_IDX) begin
                           ready_in = 1'b1;
                           vc_in    = '0;
                        end else begin
                           vc_in = vc_ff + IDX_W'(1);
                        end
                     end else begin
                        vc_in = '0;
                     end
                  end
               end else if (ready_ff) begin
                  ready_in = 1'b0;
                  sum_in   = '0;
                  sidx_in  = '0;
                  state_in = ST_SUM;
               end else begin
                  res_rate_in = '0;
                  res_done_in = 1'b0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SUM: begin
            sum_in  = sum_ff + SUM_W'(intervals_ff[sidx_ff]);
            sidx_in = sidx_ff + IDX_W'(1);
            if (sidx_ff == LAST_IDX) begin
               // average: left-aligned sum divided by the window size
               div_req.start    = 1'b1;
               div_req.steps    = DIV_STEP_W'(SUM_W);
               div_req.dividend = {sum_in, {(DIV_DIVIDEND_W - SUM_W){1'b0}}};
               div_req.divisor  = DIV_DIVISOR_W'(WINDOW_COUNT);
               state_in         = ST_AVG;
            end
         end
         ST_AVG: begin
            if (div_sts.done) begin
               if (div_sts.quotient == '0) begin
                  res_rate_in = RATE_MAX;
                  res_done_in = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.steps    = DIV_STEP_W'(DIV_DIVIDEND_W);
                  div_req.dividend = rc_ff;
                  div_req.divisor  = div_sts.quotient[DIV_DIVISOR_W-1:0];
                  state_in         = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            if (div_sts.done) begin
               // saturate quotient to eight bits
               if (div_sts.quotient[DIV_DIVIDEND_W-1:RATE_W] != '0) begin
                  res_rate_in = RATE_MAX;
               end else begin
                  res_rate_in = div_sts.quotient[RATE_W-1:0];
               end
               res_done_in = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = res_rate_ff;
               rsp_done_in  = res_done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= MIN_PERIOD_RST;
         max_ff       <= MAX_PERIOD_RST;
         rc_ff        <= RATE_CONSTANT_RST;
         vc_ff        <= '0;
         ready_ff     <= 1'b0;
         sidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rc_ff        <= rc_in;
         vc_ff        <= vc_in;
         ready_ff     <= ready_in;
         sidx_ff      <= sidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      res_rate_ff <= res_rate_in;
      res_done_ff <= res_done_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_done_ff <= rsp_done_in;
   end

   // interval store, written at the running count
   always_ff @(posedge clock) begin
      if (wr_en) begin
         intervals_ff[vc_ff] <= req_chan.period;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.rate     = rsp_rate_ff;
   assign rsp_chan.done_res = rsp_done_ff;

   `ASSERT_ALWAYS(a_ready_count_clear, clock, reset, !(ready_ff && (vc_ff != '0)), "count not cleared while result pending")
   `ASSERT_ALWAYS(a_count_range, clock, reset, vc_ff <= LAST_IDX, "interval count beyond window")
   `ASSERT_ALWAYS(a_div_no_restart, clock, reset, !(div_req.start && div_sts.busy), "divider restarted while busy")
   `ASSERT_IMPLIES(a_wait_has_div, clock, reset, (state_ff == ST_AVG) || (state_ff == ST_RATE), div_sts.busy || div_sts.done, "waiting on idle divider")
   `ASSERT_IMPLIES(a_empty_read_zero, clock, reset, rsp_valid_ff && !rsp_done_ff, rsp_rate_ff == '0, "empty read with nonzero rate")

endmodule

[tb/pphr_rate_checker.sv]
// Checker for the heart rate core: follows every transfer, predicts read results, compares.
module pphr_rate_checker import pphr_pkg::*; (
   input  logic clock,
   input  logic reset,
   pphr_req_if  req_mon,
   pphr_rsp_if  rsp_mon,
   pphr_csr_if  csr_mon,
   output int   errors,
   output int   pending
);

   localparam int WIN         = WINDOW_COUNT_DEF;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic              done_res;
   } rate_result_type;

   // shadow registers
   logic [PERIOD_W-1:0] min_per;
   logic [PERIOD_W-1:0] max_per;
   logic [RC_W-1:0]     ticks_per_min;

   // beat tracking state
   int                  beat_count;
   logic                meas_ready;
   logic [PERIOD_W-1:0] beat_iv [WIN];

   // rates owed by the block, oldest first
   rate_result_type rate_q [$];

   task automatic report(input string msg);
      if (errors < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   // Apply one accepted request; a read queues the rate it must return.
   task automatic take_request(input logic act, input logic [PERIOD_W-1:0] per);
      logic [31:0]     sum;
      logic [31:0]     avg;
      logic [31:0]     quo;
      rate_result_type res;
      if (act == ACTION_CAPTURE) begin
         // captures are dropped while a measurement waits
         if (!meas_ready) begin
            if (per > min_per && per < max_per && beat_count < WIN) begin
               beat_iv[beat_count] = per;
               beat_count++;
            end else begin
               beat_count = 0;
            end
         end
         if (beat_count >= WIN) begin
            meas_ready = 1'b1;
            beat_count = 0;
         end
      end else if (meas_ready) begin
         sum = '0;
         for (int i = 0; i < WIN; i++) sum += beat_iv[i];
         avg = sum / WIN;
         if (avg == 0) begin
            quo = RATE_MAX;
         end else begin
            quo = ticks_per_min / avg;
            if (quo > RATE_MAX) quo = RATE_MAX;
         end
         meas_ready   = 1'b0;
         res.rate     = quo[RATE_W-1:0];
         res.done_res = 1'b1;
         rate_q.push_back(res);
      end else begin
         res = '0;
         rate_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin : watch
      rate_result_type got;
      rate_result_type want;
      if (reset) begin
         min_per       = MIN_PERIOD_RST;
         max_per       = MAX_PERIOD_RST;
         ticks_per_min = RATE_CONSTANT_RST;
         beat_count    = 0;
         meas_ready    = 1'b0;
         rate_q.delete();
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_MIN_PERIOD:    min_per       = csr_mon.data[PERIOD_W-1:0];
               CSR_MAX_PERIOD:    max_per       = csr_mon.data[PERIOD_W-1:0];
               CSR_RATE_CONSTANT: ticks_per_min = csr_mon.data[RC_W-1:0];
               default: ;
            endcase
         end
         // result transfer against the oldest owed rate
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.rate     = rsp_mon.rate;
            got.done_res = rsp_mon.done_res;
            if (rate_q.size() == 0) begin
               report($sformatf("unexpected result rate=%0d done_res=%0b",
                                got.rate, got.done_res));
            end else begin
               want = rate_q.pop_front();
               if (got.rate !== want.rate)
                  report($sformatf("rate %0d, predicted %0d", got.rate, want.rate));
               if (got.done_res !== want.done_res)
                  report($sformatf("done_res %0b, predicted %0b",
                                   got.done_res, want.done_res));
            end
         end
         // request transfer
         if (req_mon.valid && req_mon.ready) take_request(req_mon.action, req_mon.period);
      end
      pending = rate_q.size();
   end

endmodule

[tb/tb.sv]
// Testbench top for the heart rate core: clock, reset, stimulus, receiver and verdict.
module tb import pphr_pkg::*; ();

   localparam int ITEM_TARGET   = 650;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int READ_LATENCY  = 56;
   localparam int SETTLE_CYCLES = READ_LATENCY + 8;
   localparam int LONG_HOLD     = 600;

   // index past the register list, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   pending;
   int   cycles     = 0;
   int   burst_left = 0;
   int   items_sent = 0;
   logic long_hold_req = 1'b0;

   // what the stimulus last wrote, used to aim periods at the window
   logic [PERIOD_W-1:0] cur_min = MIN_PERIOD_RST;
   logic [PERIOD_W-1:0] cur_max = MAX_PERIOD_RST;

   pphr_req_if req_bus ();
   pphr_rsp_if rsp_bus ();
   pphr_csr_if csr_bus ();

   pulse_period_heart_rate_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   pphr_rate_checker chk (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .csr_mon (csr_bus),
      .errors  (errors),
      .pending (pending)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: segments of open, random and patterned stalls, plus one long hold-off
   rx_mode_type rx_mode   = RX_OPEN;
   int          rx_left   = 0;
   int          rx_pos    = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic [31:0] rx_mask   = '1;

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_left = $urandom_range(8, 80);
            rx_mask = $urandom;
            rx_pos  = 0;
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_bus.ready <= rx_mask[rx_pos];
               rx_pos = (rx_pos + 1) % 32;
            end
         endcase
      end
   end

   // One request transfer; sender idles between bursts. Leaves valid high.
   task automatic push_req(input logic act, input logic [PERIOD_W-1:0] per, input bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.period <= per;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (counted) items_sent++;
   endtask

   // One register transfer; the caller lowers valid after its last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      case (idx)
         CSR_MIN_PERIOD: cur_min = value[PERIOD_W-1:0];
         CSR_MAX_PERIOD: cur_max = value[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // Drain every owed result and let a trailing read finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Idle the block, then rewrite all registers; upper data bits of the period
   // registers carry junk that must be dropped.
   task automatic apply_config(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi,
                               input logic [RC_W-1:0] rc, input bit spare);
      settle();
      if (spare) write_csr(CSR_SPARE_IDX, $urandom);
      write_csr(CSR_MIN_PERIOD, {16'($urandom), lo});
      write_csr(CSR_MAX_PERIOD, {16'($urandom), hi});
      write_csr(CSR_RATE_CONSTANT, rc);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [PERIOD_W-1:0] pick_inside();
      if (int'(cur_max) > int'(cur_min) + 1)
         return PERIOD_W'($urandom_range(int'(cur_min) + 1, int'(cur_max) - 1));
      return PERIOD_W'($urandom);
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_outside();
      if ($urandom_range(0, 1) == 1) return PERIOD_W'($urandom_range(0, int'(cur_min)));
      return PERIOD_W'($urandom_range(int'(cur_max), 65535));
   endfunction

   // Three beats in the window and a read; sometimes broken, padded or read twice.
   task automatic beat_group();
      for (int k = 0; k < WINDOW_COUNT_DEF; k++) begin
         if ($urandom_range(0, 11) == 0) push_req(ACTION_CAPTURE, pick_outside(), 1'b1);
         push_req(ACTION_CAPTURE, pick_inside(), 1'b1);
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) push_req(ACTION_CAPTURE, PERIOD_W'($urandom), 1'b0);
      push_req(ACTION_READ, PERIOD_W'($urandom), 1'b1);
      if ($urandom_range(0, 4) == 0) push_req(ACTION_READ, PERIOD_W'($urandom), 1'b1);
   endtask

   // Pick a window and a rate constant for the next phase.
   task automatic random_config();
      int          kind;
      int          lo;
      int          hi;
      logic [31:0] rc;
      kind = $urandom_range(0, 5);
      case (kind)
         0: begin
            lo = $urandom_range(0, 60000);
            hi = lo + $urandom_range(2, 65535 - lo);
            rc = ((lo + hi) / 2) * $urandom_range(0, 300);
         end
         1: begin
            lo = 0;
            hi = 65535;
            rc = $urandom;
         end
         2: begin
            // single legal period
            lo = $urandom_range(0, 65533);
            hi = lo + 2;
            rc = (lo + 1) * $urandom_range(1, 260);
         end
         3: begin
            lo = MIN_PERIOD_RST;
            hi = MAX_PERIOD_RST;
            rc = RATE_CONSTANT_RST;
         end
         4: begin
            lo = $urandom_range(0, 30000);
            hi = $urandom_range(lo + 2, 65535);
            rc = $urandom_range(1, 255);
         end
         default: begin
            // empty window
            lo = $urandom_range(1000, 65535);
            hi = $urandom_range(0, lo);
            rc = $urandom;
         end
      endcase
      apply_config(PERIOD_W'(lo), PERIOD_W'(hi), rc, $urandom_range(0, 5) == 0);
   endtask

   initial begin
      int phase_end;
      int phase_no;
      req_bus.valid  = 1'b0;
      req_bus.action = ACTION_CAPTURE;
      req_bus.period = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = CSR_MIN_PERIOD;
      csr_bus.data   = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window: read with nothing pending, boundaries, then three good beats
      push_req(ACTION_READ, 16'h0000, 1'b1);
      push_req(ACTION_CAPTURE, 16'h0000, 1'b1);
      push_req(ACTION_CAPTURE, 16'hFFFF, 1'b1);
      push_req(ACTION_CAPTURE, MIN_PERIOD_RST, 1'b1);
      push_req(ACTION_CAPTURE, MAX_PERIOD_RST, 1'b1);
      push_req(ACTION_CAPTURE, MIN_PERIOD_RST + 1, 1'b1);
      push_req(ACTION_CAPTURE, MAX_PERIOD_RST - 1, 1'b1);
      push_req(ACTION_CAPTURE, 16'd8000, 1'b1);
      // capture while a measurement waits is dropped
      push_req(ACTION_CAPTURE, 16'd5000, 1'b1);
      push_req(ACTION_READ, 16'hFFFF, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);
      // out-of-window beat restarts the count
      push_req(ACTION_CAPTURE, 16'd5000, 1'b1);
      push_req(ACTION_CAPTURE, 16'd6000, 1'b1);
      push_req(ACTION_CAPTURE, 16'd20000, 1'b1);
      repeat (3) push_req(ACTION_CAPTURE, 16'd7000, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);

      // full window, largest constant: quotient saturates at both ends of the average
      apply_config(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      repeat (3) push_req(ACTION_CAPTURE, 16'd1, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);
      push_req(ACTION_CAPTURE, 16'hFFFE, 1'b1);
      push_req(ACTION_CAPTURE, 16'hFFFE, 1'b1);
      push_req(ACTION_CAPTURE, 16'hFFFD, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);

      // zero rate constant: rate 0 with done set
      apply_config(16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0);
      push_req(ACTION_CAPTURE, 16'd100, 1'b1);
      push_req(ACTION_CAPTURE, 16'd200, 1'b1);
      push_req(ACTION_CAPTURE, 16'd300, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);

      // inverted window: nothing is ever valid
      apply_config(16'hFFFF, 16'h0000, 32'h0000_0001, 1'b0);
      push_req(ACTION_CAPTURE, 16'd30000, 1'b1);
      push_req(ACTION_READ, 16'h0000, 1'b1);

      // random phases; the first one runs against a long receiver hold-off
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         random_config();
         if (phase_no == 0) long_hold_req <= 1'b1;
         phase_no++;
         phase_end = items_sent + $urandom_range(30, 80);
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) begin
               beat_group();
            end else begin
               repeat ($urandom_range(1, 6))
                  push_req($urandom_range(0, 1) ? ACTION_READ : ACTION_CAPTURE,
                           PERIOD_W'($urandom), 1'b1);
            end
         end
      end

      // drain and watch for stray results
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2 * READ_LATENCY) @(negedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
